/* sv/oli_pkg.sv */
// ----------------------------------------------------------------------------
// oli_pkg: shared types and constants for the ordered list core
// Request/response field widths, mode and status codes, cell control.
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int unsigned ModeW   = 3;
  localparam int unsigned PosW    = 7;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatW   = 2;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CapW    = 7;

  localparam int unsigned DefListDepth = 64;
  localparam logic [CapW-1:0] CapReset = CapW'(64);

  // Reported for front/back of an empty list
  localparam logic signed [ValW-1:0] EmptyVal = '1;

  typedef enum logic [ModeW-1:0] {
    MODE_APPEND     = 3'd0,
    MODE_INSERT     = 3'd1,
    MODE_REMOVE_AT  = 3'd2,
    MODE_POP_FRONT  = 3'd3,
    MODE_POP_BACK   = 3'd4,
    MODE_CLEAR      = 3'd5
  } mode_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK        = 2'd0,
    STAT_OVERFLOW  = 2'd1,
    STAT_UNDERFLOW = 2'd2,
    STAT_INVALID   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } ctrl_state_e;

  // Control broadcast to every cell of the row
  typedef struct packed {
    cell_op_e op;
    logic     tap_load;
    logic     tap_shift;
  } cell_ctrl_t;

endpackage

/* sv/oli_if.sv */
// ----------------------------------------------------------------------------
// oli_if: request and response channels of the ordered list core
// Valid/ready handshake; an item moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface oli_req_if import oli_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ModeW-1:0]       mode;
  logic [PosW-1:0]        position;
  logic signed [ValW-1:0] item_value;

  modport source (output valid, mode, position, item_value, input ready);
  modport sink   (input valid, mode, position, item_value, output ready);
endinterface

interface oli_rsp_if import oli_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [StatW-1:0]       status;
  logic [CountW-1:0]      item_count;
  logic signed [ValW-1:0] front_value;
  logic signed [ValW-1:0] back_value;

  modport source (output valid, status, item_count, front_value, back_value, input ready);
  modport sink   (input valid, status, item_count, front_value, back_value, output ready);
endinterface

/* sv/oli_cell.sv */
// ----------------------------------------------------------------------------
// oli_cell: one storage cell of the list row
// Holds one entry; takes its left or right neighbor on insert/remove, and
// carries a tap register that shifts toward cell zero to read the back entry.
// ----------------------------------------------------------------------------
module oli_cell import oli_pkg::*; #(
  parameter int unsigned ListDepth = DefListDepth,
  parameter int unsigned Idx       = 0
) (
  input  logic                         clk_i,
  input  cell_ctrl_t                   ctrl_i,
  input  logic [$clog2(ListDepth)-1:0] pos_i,
  input  logic signed [ValW-1:0]       val_i,
  input  logic signed [ValW-1:0]       left_i,
  input  logic signed [ValW-1:0]       right_i,
  input  logic signed [ValW-1:0]       tap_right_i,
  output logic signed [ValW-1:0]       entry_o,
  output logic signed [ValW-1:0]       tap_o
);

  localparam int unsigned IdxW = $clog2(ListDepth);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(Idx);

  logic signed [ValW-1:0] entry_q, entry_d;
  logic signed [ValW-1:0] tap_q, tap_d;

  // Entry update
  always_comb begin
    entry_d = entry_q;
    unique case (ctrl_i.op)
      CELL_INSERT: begin
        if (MyIdx > pos_i) begin
          entry_d = left_i;
        end else if (MyIdx == pos_i) begin
          entry_d = val_i;
        end
      end
      CELL_REMOVE: begin
        if (MyIdx >= pos_i) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  // Tap chain: load from the updated entry, then shift down one per cycle
  always_comb begin
    tap_d = tap_q;
    if (ctrl_i.tap_load) begin
      tap_d = entry_d;
    end else if (ctrl_i.tap_shift) begin
      tap_d = tap_right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    tap_q   <= tap_d;
  end

  assign entry_o = entry_q;
  assign tap_o   = tap_q;

endmodule

/* sv/oli_ctrl.sv */
// ----------------------------------------------------------------------------
// oli_ctrl: request decode, fill count and sequencing of the cell row
// Checks each request, drives the row for its update, then walks the
// tap chain to fetch the back entry and registers the response.
// ----------------------------------------------------------------------------
module oli_ctrl import oli_pkg::*; #(
  parameter int unsigned ListDepth = DefListDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CapW-1:0]              cfg_wdata_i,
  oli_req_if.sink                      req,
  oli_rsp_if.source                    rsp,
  output cell_ctrl_t                   cell_ctrl_o,
  output logic [$clog2(ListDepth)-1:0] cell_pos_o,
  output logic signed [ValW-1:0]       cell_val_o,
  input  logic signed [ValW-1:0]       front_i,
  input  logic signed [ValW-1:0]       back_tap_i
);

  localparam int unsigned IdxW  = $clog2(ListDepth);
  localparam int unsigned CntW  = $clog2(ListDepth + 1);
  localparam int unsigned CmpW  = (CntW > CapW) ? CntW : CapW;
  localparam logic [CmpW-1:0] DepthC = CmpW'(ListDepth);

  ctrl_state_e state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CapW-1:0]   cap_q;
  logic [IdxW-1:0]   scan_q, scan_d;
  logic [StatW-1:0]  stat_q, stat_d;
  logic              out_valid_q, out_valid_d;
  logic [StatW-1:0]  out_stat_q;
  logic [CountW-1:0] out_count_q;
  logic signed [ValW-1:0] out_front_q, out_back_q;
  logic              out_load;

  logic [CmpW-1:0] cap_eff, count_ext, pos_ext;
  logic            full, accept;

  // Effective capacity: zero acts as one, clamp at the row length
  always_comb begin
    cap_eff = CmpW'(cap_q);
    if (cap_q == '0) begin
      cap_eff = CmpW'(1);
    end else if (cap_eff > DepthC) begin
      cap_eff = DepthC;
    end
  end

  assign count_ext = CmpW'(count_q);
  assign pos_ext   = CmpW'(req.position);
  assign full      = count_ext >= cap_eff;
  assign accept    = req.valid && req.ready;
  assign req.ready = (state_q == ST_IDLE);
  assign cell_val_o = req.item_value;

  // Next state, row control and status
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    scan_d      = scan_q;
    stat_d      = stat_q;
    out_load    = 1'b0;
    cell_ctrl_o = '{op: CELL_HOLD, tap_load: 1'b0, tap_shift: 1'b0};
    cell_pos_o  = IdxW'(pos_ext);
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          stat_d = STAT_OK;
          unique case (req.mode)
            MODE_APPEND: begin
              if (full) begin
                stat_d = STAT_OVERFLOW;
              end else begin
                cell_ctrl_o.op = CELL_INSERT;
                cell_pos_o     = IdxW'(count_ext);
                count_d        = count_q + CntW'(1);
              end
            end
            MODE_INSERT: begin
              if (full) begin
                stat_d = STAT_OVERFLOW;
              end else if (pos_ext > count_ext) begin
                stat_d = STAT_INVALID;
              end else begin
                cell_ctrl_o.op = CELL_INSERT;
                count_d        = count_q + CntW'(1);
              end
            end
            MODE_REMOVE_AT: begin
              if (count_q == '0) begin
                stat_d = STAT_UNDERFLOW;
              end else if (pos_ext >= count_ext) begin
                stat_d = STAT_INVALID;
              end else begin
                cell_ctrl_o.op = CELL_REMOVE;
                count_d        = count_q - CntW'(1);
              end
            end
            MODE_POP_FRONT: begin
              if (count_q != '0) begin
                cell_ctrl_o.op = CELL_REMOVE;
                cell_pos_o     = '0;
                count_d        = count_q - CntW'(1);
              end
            end
            MODE_POP_BACK: begin
              if (count_q != '0) begin
                count_d = count_q - CntW'(1);
              end
            end
            MODE_CLEAR: count_d = '0;
            default:    stat_d  = STAT_INVALID;
          endcase
          // Load taps with the updated entries; back sits count-1 cells up
          cell_ctrl_o.tap_load = 1'b1;
          scan_d  = (count_d == '0) ? '0 : IdxW'(count_d - CntW'(1));
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cell_ctrl_o.tap_shift = 1'b1;
          scan_d = scan_q - IdxW'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cap_q       <= CapReset;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    stat_q <= stat_d;
    if (out_load) begin
      out_stat_q  <= stat_q;
      out_count_q <= CountW'(count_ext);
      out_front_q <= (count_q == '0) ? EmptyVal : front_i;
      out_back_q  <= (count_q == '0) ? EmptyVal : back_tap_i;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_stat_q;
  assign rsp.item_count  = out_count_q;
  assign rsp.front_value = out_front_q;
  assign rsp.back_value  = out_back_q;

  // Fill count never exceeds the row
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_ext <= DepthC)
    else $error("fill count beyond row length");

  // Clear empties the list
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && req.mode == MODE_CLEAR) |=> (count_q == '0))
    else $error("clear left entries");

  // Sequencer leaves idle only on an accepted item
  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && !accept) |=> (state_q == ST_IDLE))
    else $error("sequencer left idle without an item");

  // A new response only comes from the done step
  a_rsp_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_DONE))
    else $error("response raised outside done step");

endmodule

/* sv/ordered_list_insert_remove_core.sv */
// ----------------------------------------------------------------------------
// ordered_list_insert_remove_core: bounded ordered list with positional
// insert and remove, built as a row of shifting cells.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  req_i     in   valid/ready        mode, position, item_value
//  rsp_o     out  valid/ready        status, item_count, front_value, back_value
//  cfg       in   cfg_we_i           cfg_wdata_i (list capacity)
//
//  An item runs through an update step that drives the row and loads the
//  taps, tap shifts that bring the back entry to cell zero, a step that
//  ends the scan, and a step that loads the response register.
//  The next item is taken while a response still waits in its register;
//  a stalled response holds the sequencer in its done step.
//  Reset clears the fill count and sets the capacity to 64; entries are
//  not cleared.
// ----------------------------------------------------------------------------
module ordered_list_insert_remove_core import oli_pkg::*; #(
  parameter int unsigned ListDepth = DefListDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CapW-1:0] cfg_wdata_i,
  oli_req_if.sink         req_i,
  oli_rsp_if.source       rsp_o
);

  localparam int unsigned IdxW = $clog2(ListDepth);

  cell_ctrl_t             cell_ctrl;
  logic [IdxW-1:0]        cell_pos;
  logic signed [ValW-1:0] cell_val;
  logic signed [ValW-1:0] entry [ListDepth];
  logic signed [ValW-1:0] tap   [ListDepth];

  oli_ctrl #(.ListDepth(ListDepth)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_i),
    .rsp         (rsp_o),
    .cell_ctrl_o (cell_ctrl),
    .cell_pos_o  (cell_pos),
    .cell_val_o  (cell_val),
    .front_i     (entry[0]),
    .back_tap_i  (tap[0])
  );

  // Row of cells; ends feed back their own value
  for (genvar i = 0; i < ListDepth; i++) begin : g_cell
    logic signed [ValW-1:0] left_v, right_v, tap_right_v;
    if (i == 0) begin : g_first
      assign left_v = entry[i];
    end else begin : g_mid_l
      assign left_v = entry[i-1];
    end
    if (i == ListDepth - 1) begin : g_last
      assign right_v     = entry[i];
      assign tap_right_v = tap[i];
    end else begin : g_mid_r
      assign right_v     = entry[i+1];
      assign tap_right_v = tap[i+1];
    end

    oli_cell #(.ListDepth(ListDepth), .Idx(i)) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .pos_i       (cell_pos),
      .val_i       (cell_val),
      .left_i      (left_v),
      .right_i     (right_v),
      .tap_right_i (tap_right_v),
      .entry_o     (entry[i]),
      .tap_o       (tap[i])
    );
  end

endmodule
